// ===== rtl/aabb_contact_pair_tracker_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the contact pair tracker
// Shared forms for concurrent checks, clocked on the rising edge with an
// active-low reset that disables the check.
// ---------------------------------------------------------------------------
`ifndef AABB_CONTACT_PAIR_TRACKER_ASSERT_SVH
`define AABB_CONTACT_PAIR_TRACKER_ASSERT_SVH

// Same-cycle implication
`define ACPT_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ACPT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/acpt_pkg.sv =====
// ---------------------------------------------------------------------------
// acpt_pkg
// Types, codes and defaults shared by the contact pair tracker modules.
// ---------------------------------------------------------------------------
`default_nettype none

package acpt_pkg;

    localparam int DEF_MAX_OBJECTS = 32;
    localparam int DEF_COORD_BITS  = 16;
    localparam int ID_W            = 5;
    localparam int EDGE_W          = 16;

    typedef enum logic
    {
        OP_CHECK  = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0]
    {
        EV_NONE  = 2'd0,
        EV_ENTER = 2'd1,
        EV_STAY  = 2'd2,
        EV_EXIT  = 2'd3
    } event_t;

    typedef struct packed
    {
        op_t                      op;
        logic [ID_W-1:0]          id_first;
        logic [ID_W-1:0]          id_second;
        logic                     both_enabled;
        logic signed [EDGE_W-1:0] left_a;
        logic signed [EDGE_W-1:0] right_a;
        logic signed [EDGE_W-1:0] top_a;
        logic signed [EDGE_W-1:0] bottom_a;
        logic signed [EDGE_W-1:0] left_b;
        logic signed [EDGE_W-1:0] right_b;
        logic signed [EDGE_W-1:0] top_b;
        logic signed [EDGE_W-1:0] bottom_b;
    } in_item_t;

    typedef struct packed
    {
        event_t          event_res;
        logic [ID_W-1:0] notify_id;
        logic [ID_W-1:0] other_id;
        logic            last;
    } out_item_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_CHK,
        ST_REM_ROWA,
        ST_REM_ROW,
        ST_REM_COL,
        ST_REM_END
    } state_t;

    // controller -> datapath
    typedef struct packed
    {
        logic take_item;
        logic check_eval;
        logic load_rowa;
        logic row_step;
        logic col_step;
        logic finish;
    } cmd_t;

    // datapath -> controller
    typedef struct packed
    {
        op_t  in_op;
        logic a_ok;
        logic out_free;
        logic row_hit;
        logic col_hit;
        logic pend_valid;
        logic j_last;
    } sts_t;

endpackage

`default_nettype wire

// ===== rtl/acpt_ram.sv =====
// ---------------------------------------------------------------------------
// acpt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module acpt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/acpt_ctrl.sv =====
// ---------------------------------------------------------------------------
// acpt_ctrl
// Sequencer for pair checks and object removal walks.
// ---------------------------------------------------------------------------
`default_nettype none

module acpt_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire acpt_pkg::sts_t sts,
    output acpt_pkg::cmd_t     cmd
);

    import acpt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = (sts.in_op == OP_CHECK) ? ST_CHK : ST_REM_ROWA;
                end
            end
            ST_CHK:
            begin
                if (sts.out_free)
                begin
                    cmd.check_eval = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_REM_ROWA:
            begin
                if (sts.a_ok)
                begin
                    cmd.load_rowa = 1'b1;
                    state_next    = ST_REM_ROW;
                end
                else
                begin
                    state_next = ST_REM_END;
                end
            end
            ST_REM_ROW:
            begin
                // a new exit only needs the output when one is already pending
                if (!(sts.row_hit && sts.pend_valid && !sts.out_free))
                begin
                    cmd.row_step = 1'b1;
                    state_next   = ST_REM_COL;
                end
            end
            ST_REM_COL:
            begin
                if (!(sts.col_hit && sts.pend_valid && !sts.out_free))
                begin
                    cmd.col_step = 1'b1;
                    state_next   = sts.j_last ? ST_REM_END : ST_REM_ROW;
                end
            end
            ST_REM_END:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/acpt_dp.sv =====
// ---------------------------------------------------------------------------
// acpt_dp
// Contact bitmap, overlap test, removal scan and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module acpt_dp #(
    parameter int MAX_OBJECTS = acpt_pkg::DEF_MAX_OBJECTS,
    parameter int COORD_BITS  = acpt_pkg::DEF_COORD_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire acpt_pkg::cmd_t     cmd,
    output acpt_pkg::sts_t          sts,
    input  wire acpt_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output acpt_pkg::out_item_t     out_item
);

    import acpt_pkg::*;

    localparam int IDX_W = $clog2(MAX_OBJECTS);

    in_item_t               item_reg;
    logic [IDX_W-1:0]       j_reg;
    logic [IDX_W-1:0]       j_next;
    logic [IDX_W-1:0]       a_idx;
    logic [IDX_W-1:0]       b_idx;
    logic [MAX_OBJECTS-1:0] row_valid_reg;
    logic [MAX_OBJECTS-1:0] row_valid_next;
    logic [MAX_OBJECTS-1:0] rowa_reg;
    logic [MAX_OBJECTS-1:0] rowa_next;
    logic [MAX_OBJECTS-1:0] rdata;
    logic [MAX_OBJECTS-1:0] rdata_eff;
    logic [MAX_OBJECTS-1:0] wr_data;
    logic [IDX_W-1:0]       wr_addr;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic                   rd_en;
    logic                   rd_valid_reg;
    logic                   pend_valid_reg;
    logic                   pend_valid_next;
    logic [ID_W-1:0]        pend_id_reg;
    logic [ID_W-1:0]        pend_id_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_reg;
    out_item_t              out_next;
    logic                   push;
    out_item_t              push_item;
    logic                   a_ok;
    logic                   b_ok;
    logic                   en;
    logic                   hit;
    logic                   was;
    logic                   row_hit;
    logic                   col_hit;
    event_t                 chk_ev;

    logic signed [COORD_BITS-1:0] la;
    logic signed [COORD_BITS-1:0] ra;
    logic signed [COORD_BITS-1:0] ta;
    logic signed [COORD_BITS-1:0] ba;
    logic signed [COORD_BITS-1:0] lb;
    logic signed [COORD_BITS-1:0] rb;
    logic signed [COORD_BITS-1:0] tb;
    logic signed [COORD_BITS-1:0] bb;

    acpt_ram #(
        .WIDTH (MAX_OBJECTS),
        .DEPTH (MAX_OBJECTS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rdata)
    );

    assign a_idx = IDX_W'(item_reg.id_first);
    assign b_idx = IDX_W'(item_reg.id_second);
    assign a_ok  = 32'(item_reg.id_first) < 32'(MAX_OBJECTS);
    assign b_ok  = 32'(item_reg.id_second) < 32'(MAX_OBJECTS);

    // rows never written since reset or last removal read as empty
    assign rdata_eff = rd_valid_reg ? rdata : '0;

    // coordinates as COORD_BITS-bit two's complement values
    assign la = COORD_BITS'(item_reg.left_a);
    assign ra = COORD_BITS'(item_reg.right_a);
    assign ta = COORD_BITS'(item_reg.top_a);
    assign ba = COORD_BITS'(item_reg.bottom_a);
    assign lb = COORD_BITS'(item_reg.left_b);
    assign rb = COORD_BITS'(item_reg.right_b);
    assign tb = COORD_BITS'(item_reg.top_b);
    assign bb = COORD_BITS'(item_reg.bottom_b);

    assign hit = (la <= rb) && (ra >= lb) && (ta <= bb) && (ba >= tb);
    assign en  = item_reg.both_enabled && a_ok && b_ok;
    assign was = rdata_eff[b_idx];

    always_comb
    begin
        chk_ev = EV_NONE;
        if (en)
        begin
            if (was && hit)
            begin
                chk_ev = EV_STAY;
            end
            else if (was)
            begin
                chk_ev = EV_EXIT;
            end
            else if (hit)
            begin
                chk_ev = EV_ENTER;
            end
        end
    end

    // row step clears row a bit a; col_hit skips j == a, so the self pair counts once
    assign row_hit = rowa_reg[j_reg];
    assign col_hit = (j_reg != a_idx) && rdata_eff[a_idx];

    always_comb
    begin
        j_next          = j_reg;
        rowa_next       = rowa_reg;
        row_valid_next  = row_valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        push            = 1'b0;
        push_item       = '0;
        wr_en           = 1'b0;
        wr_addr         = a_idx;
        wr_data         = rdata_eff;
        rd_en           = 1'b0;
        rd_addr         = j_reg;

        if (cmd.take_item)
        begin
            rd_en           = 1'b1;
            rd_addr         = IDX_W'(in_item.id_first);
            pend_valid_next = 1'b0;
            j_next          = '0;
        end

        if (cmd.check_eval)
        begin
            push                = 1'b1;
            push_item.event_res = chk_ev;
            push_item.notify_id = item_reg.id_first;
            push_item.other_id  = item_reg.id_second;
            push_item.last      = 1'b1;
            if (en && (was != hit))
            begin
                wr_en          = 1'b1;
                wr_addr        = a_idx;
                wr_data[b_idx] = hit;
            end
        end

        if (cmd.load_rowa)
        begin
            rowa_next             = rdata_eff;
            row_valid_next[a_idx] = 1'b0;
        end

        if (cmd.row_step)
        begin
            rd_en   = 1'b1;
            rd_addr = j_reg;
            if (row_hit)
            begin
                rowa_next[j_reg]    = 1'b0;
                push                = pend_valid_reg;
                push_item.event_res = EV_EXIT;
                push_item.notify_id = pend_id_reg;
                push_item.other_id  = item_reg.id_first;
                push_item.last      = 1'b0;
                pend_valid_next     = 1'b1;
                pend_id_next        = ID_W'(j_reg);
            end
        end

        if (cmd.col_step)
        begin
            j_next = j_reg + 1'b1;
            if (col_hit)
            begin
                push                = pend_valid_reg;
                push_item.event_res = EV_EXIT;
                push_item.notify_id = pend_id_reg;
                push_item.other_id  = item_reg.id_first;
                push_item.last      = 1'b0;
                pend_valid_next     = 1'b1;
                pend_id_next        = ID_W'(j_reg);
                wr_en               = 1'b1;
                wr_addr             = j_reg;
                wr_data[a_idx]      = 1'b0;
            end
        end

        if (cmd.finish)
        begin
            push                = 1'b1;
            push_item.event_res = pend_valid_reg ? EV_EXIT : EV_NONE;
            push_item.notify_id = pend_valid_reg ? pend_id_reg : item_reg.id_first;
            push_item.other_id  = item_reg.id_first;
            push_item.last      = 1'b1;
        end

        if (wr_en)
        begin
            row_valid_next[wr_addr] = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_item;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            row_valid_reg  <= row_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= in_item;
        end
        j_reg       <= j_next;
        rowa_reg    <= rowa_next;
        pend_id_reg <= pend_id_next;
        out_reg     <= out_next;
    end

    always_comb
    begin
        sts.in_op      = in_item.op;
        sts.a_ok       = a_ok;
        sts.out_free   = !out_valid_reg || !out_stall;
        sts.row_hit    = row_hit;
        sts.col_hit    = col_hit;
        sts.pend_valid = pend_valid_reg;
        sts.j_last     = 32'(j_reg) == 32'(MAX_OBJECTS - 1);
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule

`default_nettype wire

// ===== rtl/aabb_contact_pair_tracker.sv =====
// ---------------------------------------------------------------------------
// aabb_contact_pair_tracker
// Tracks contact between ordered object pairs with a box overlap test.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item): a check item tests two boxes
// and updates the pair's contact bit; a remove item clears every contact of
// one object. Output channel (out_valid / out_stall / out_item): result items,
// with last set on the final result of each input item.
// Check: one result; the bitmap row is read, then the overlap test runs and
// the row is written back.
// Remove: up to 2*MAX_OBJECTS - 1 results; the scan visits every row of the
// bitmap RAM once through the single RAM read port. An id at or above
// MAX_OBJECTS gives one none result.
// Output stall: one result waits in the output register while work goes on;
// the scan holds only when a second result is ready. in_stall is high from
// the cycle after a transfer until the item's last result is registered.
// Reset: every pair reads as not in contact (per-row valid flops cleared).
// ---------------------------------------------------------------------------
`default_nettype none

module aabb_contact_pair_tracker #(
    parameter int MAX_OBJECTS = acpt_pkg::DEF_MAX_OBJECTS,
    parameter int COORD_BITS  = acpt_pkg::DEF_COORD_BITS
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire acpt_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output acpt_pkg::out_item_t     out_item
);

    import acpt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    acpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    acpt_dp #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

// ===== rtl/acpt_checker.sv =====
// ---------------------------------------------------------------------------
// acpt_checker
// Port-level checks for the contact pair tracker, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "aabb_contact_pair_tracker_assert.svh"

module acpt_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_stall,
    input wire logic                out_valid,
    input wire logic                out_stall,
    input wire acpt_pkg::out_item_t out_item
);

    import acpt_pkg::*;

    // a stalled result holds
    `ACPT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(out_item), "stalled result changed")

    // one item at a time: busy right after a transfer
    `ACPT_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && !in_stall,
        in_stall, "input taken again before the item finished")

    // a none result is always the only result of its item
    `ACPT_ASSERT_IMPLY(a_none_last, clk, rst_n,
        out_valid && (out_item.event_res == EV_NONE),
        out_item.last, "none result without last")

    // enter and stay come only from checks, which give one result
    `ACPT_ASSERT_IMPLY(a_chk_last, clk, rst_n,
        out_valid && ((out_item.event_res == EV_ENTER) || (out_item.event_res == EV_STAY)),
        out_item.last, "check result without last")

endmodule

bind aabb_contact_pair_tracker acpt_checker u_acpt_checker (.*);

`default_nettype wire
